[src/assert_macros.svh]
// Assertion macros shared by the quaternion unit.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define QAU_ASSERT_IMP(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("quaternion unit: same-cycle check failed");

// Next-cycle implication.
`define QAU_ASSERT_NXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("quaternion unit: next-cycle check failed");

`endif

[src/qau_pkg.sv]
// Shared types, constants and saturation helpers of the quaternion unit.
// No dependencies.
package qau_pkg;

   localparam int COMP_W          = 32;
   localparam int FRAC_W          = 28;
   localparam int WORD_W          = 64;
   localparam int HALF_W          = WORD_W / 2;
   localparam int PROD_W          = 2 * WORD_W;
   localparam int SAT_W           = 2 * COMP_W + 2;
   localparam int NORM_W          = 2 * COMP_W + 1;
   localparam int Q_FRAC          = WORD_W - 2;
   localparam int NEWTON_STAGES   = 7;
   localparam int DEF_RSQRT_ITERS = 3;
   localparam int FIFO_DEPTH      = 2;
   localparam int NORM_SH_BASE    = Q_FRAC - FRAC_W;

   localparam logic [2:0] OP_MUL  = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_CONJ = 3'd3;
   localparam logic [2:0] OP_DOT  = 3'd4;
   localparam logic [2:0] OP_NORM = 3'd5;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef comp_type [3:0] quat_type;
   typedef logic [WORD_W-1:0] word_type;

   localparam comp_type COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
   localparam comp_type COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

   localparam word_type Q62_ONE   = word_type'(1) << Q_FRAC;
   localparam word_type Q62_THREE = word_type'(3) << Q_FRAC;

   typedef enum logic [2:0] {
      KIND_MUL, KIND_ADD, KIND_SUB, KIND_CONJ, KIND_DOT, KIND_NORM, KIND_NONE
   } kind_type;

   typedef struct packed {
      kind_type kind;
      quat_type a;
      quat_type b;
   } item_type;

   typedef struct packed {
      quat_type res;
      comp_type scalar;
      logic     sat;
   } result_type;

   typedef struct packed {
      logic full;
      logic pop;
   } queue_stat_type;

   function automatic logic signed [SAT_W-1:0] ext_comp(input comp_type v);
      return {{(SAT_W-COMP_W){v[COMP_W-1]}}, v};
   endfunction

   function automatic logic signed [SAT_W-1:0] ext_word(input logic [WORD_W-1:0] v);
      return {{(SAT_W-WORD_W){v[WORD_W-1]}}, v};
   endfunction

   // {clipped flag, value}
   function automatic logic [COMP_W:0] sat_fn(input logic signed [SAT_W-1:0] x);
      logic [SAT_W-COMP_W:0] top;
      logic [COMP_W:0]       r;
      top = x[SAT_W-1:COMP_W-1];
      if ((&top) || !(|top)) r = {1'b0, x[COMP_W-1:0]};
      else if (x[SAT_W-1])   r = {1'b1, COMP_MIN};
      else                   r = {1'b1, COMP_MAX};
      return r;
   endfunction

endpackage

[src/qau_front.sv]
// Front end: accepts request items and classifies the opcode.
// Depends on qau_pkg.
module qau_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [2:0]          in_op,
   input  qau_pkg::quat_type   in_a,
   input  qau_pkg::quat_type   in_b,
   output logic                out_valid,
   input  logic                out_ready,
   output qau_pkg::item_type   item_out
);

   logic               valid_ff;
   qau_pkg::item_type  item_ff;
   qau_pkg::kind_type  kind_in;

   always_comb begin
      unique case (in_op)
         qau_pkg::OP_MUL:  kind_in = qau_pkg::KIND_MUL;
         qau_pkg::OP_ADD:  kind_in = qau_pkg::KIND_ADD;
         qau_pkg::OP_SUB:  kind_in = qau_pkg::KIND_SUB;
         qau_pkg::OP_CONJ: kind_in = qau_pkg::KIND_CONJ;
         qau_pkg::OP_DOT:  kind_in = qau_pkg::KIND_DOT;
         qau_pkg::OP_NORM: kind_in = qau_pkg::KIND_NORM;
         default:          kind_in = qau_pkg::KIND_NONE;
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign item_out  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
      if (in_valid && in_ready) begin
         item_ff.kind <= kind_in;
         item_ff.a    <= in_a;
         item_ff.b    <= in_b;
      end
   end

endmodule

[src/qau_fifo.sv]
// Short queue between the front end and the execution pipeline.
// Depends on qau_pkg.
module qau_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  qau_pkg::item_type        item_in,
   output logic                     out_valid,
   input  logic                     out_ready,
   output qau_pkg::item_type        item_out,
   output qau_pkg::queue_stat_type  stat
);

   localparam int PTR_W = $clog2(qau_pkg::FIFO_DEPTH);

   qau_pkg::item_type   mem_ff [qau_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]      count_ff;
   logic                push, pop;

   assign in_ready  = count_ff != (PTR_W+1)'(qau_pkg::FIFO_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign item_out  = mem_ff[rd_ptr_ff];
   assign stat.full = !in_ready;
   assign stat.pop  = pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(qau_pkg::FIFO_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(qau_pkg::FIFO_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

[src/qau_mul64.sv]
// Two-stage 64 x 64 unsigned multiplier built from four 32 x 32 partial products.
// Depends on qau_pkg.
module qau_mul64 (
   input  logic                          clock,
   input  logic                          en,
   input  qau_pkg::word_type             op_a,
   input  qau_pkg::word_type             op_b,
   output logic [qau_pkg::PROD_W-1:0]    prod
);

   localparam int HW = qau_pkg::HALF_W;

   qau_pkg::word_type              ll_ff, lh_ff, hl_ff, hh_ff;
   logic [qau_pkg::PROD_W-1:0]     prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff   <= op_a[HW-1:0] * op_b[HW-1:0];
         lh_ff   <= op_a[HW-1:0] * op_b[2*HW-1:HW];
         hl_ff   <= op_a[2*HW-1:HW] * op_b[HW-1:0];
         hh_ff   <= op_a[2*HW-1:HW] * op_b[2*HW-1:HW];
         prod_ff <= {hh_ff, ll_ff} + {{HW{1'b0}}, lh_ff, {HW{1'b0}}}
                                   + {{HW{1'b0}}, hl_ff, {HW{1'b0}}};
      end
   end

   assign prod = prod_ff;

endmodule

[src/qau_newton.sv]
// One Newton step of the inverse square root: y = y * (3 - m*y*y) / 2.
// Depends on qau_pkg and qau_mul64; seven register stages.
module qau_newton (
   input  logic                clock,
   input  logic                en,
   input  qau_pkg::word_type   m_in,
   input  qau_pkg::word_type   y_in,
   output qau_pkg::word_type   m_out,
   output qau_pkg::word_type   y_out
);

   localparam int QF = qau_pkg::Q_FRAC;
   localparam int WW = qau_pkg::WORD_W;

   qau_pkg::word_type           m_dly_ff [qau_pkg::NEWTON_STAGES];
   qau_pkg::word_type           y_dly_ff [5];
   qau_pkg::word_type           v_ff;
   qau_pkg::word_type           t_val, u_val;
   logic [qau_pkg::PROD_W-1:0]  prod_sq, prod_mt, prod_yv;

   qau_mul64 u_mul_sq (.clock(clock), .en(en), .op_a(y_in), .op_b(y_in), .prod(prod_sq));
   assign t_val = prod_sq[QF+WW-1:QF];

   qau_mul64 u_mul_mt (.clock(clock), .en(en), .op_a(m_dly_ff[1]), .op_b(t_val),
                       .prod(prod_mt));
   assign u_val = prod_mt[QF+WW-1:QF];

   qau_mul64 u_mul_yv (.clock(clock), .en(en), .op_a(y_dly_ff[4]), .op_b(v_ff),
                       .prod(prod_yv));

   always_ff @(posedge clock) begin
      if (en) begin
         m_dly_ff[0] <= m_in;
         for (int i = 1; i < qau_pkg::NEWTON_STAGES; i++) m_dly_ff[i] <= m_dly_ff[i-1];
         y_dly_ff[0] <= y_in;
         for (int i = 1; i < 5; i++) y_dly_ff[i] <= y_dly_ff[i-1];
         // clamp 3 - u at zero
         v_ff <= (u_val >= qau_pkg::Q62_THREE) ? '0 : qau_pkg::Q62_THREE - u_val;
      end
   end

   assign m_out = m_dly_ff[qau_pkg::NEWTON_STAGES-1];
   assign y_out = prod_yv[QF+WW:QF+1];

endmodule

[src/qau_back.sv]
// Execution pipeline: products, sums, saturation and the normalize path.
// Depends on qau_pkg and qau_newton.
module qau_back #(
   parameter int RSQRT_ITERS = qau_pkg::DEF_RSQRT_ITERS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  qau_pkg::item_type    item_in,
   output logic                 out_valid,
   input  logic                 out_ready,
   output qau_pkg::result_type  result_out
);

   localparam int CW     = qau_pkg::COMP_W;
   localparam int WW     = qau_pkg::WORD_W;
   localparam int HW     = qau_pkg::HALF_W;
   localparam int SW     = qau_pkg::SAT_W;
   localparam int NW     = qau_pkg::NORM_W;
   localparam int QF     = qau_pkg::Q_FRAC;
   localparam int NL     = RSQRT_ITERS * qau_pkg::NEWTON_STAGES;
   localparam int TOTAL  = 6 + NL + 4;
   localparam int GRP_N  = (NW + 7) / 8;
   localparam int GRP_W  = $clog2(GRP_N);
   localparam int P_W    = GRP_W + 3;
   localparam int H_W    = P_W - 1;
   localparam int SH_W   = H_W + 1;
   localparam int PL_W   = CW + HW + 1;
   localparam int LONG_W = CW + WW + 1;

   typedef struct packed {
      logic                is_norm;
      logic                zero;
      logic [H_W-1:0]      h;
      qau_pkg::quat_type   a;
      qau_pkg::result_type res;
   } side_type;

   logic [TOTAL-1:0] vld_ff;
   logic             en;

   assign en         = !vld_ff[TOTAL-1] || out_ready;
   assign in_ready   = en;
   assign out_valid  = vld_ff[TOTAL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL-2:0], in_valid};
      end
   end

   // stage 1: products and simple ops
   qau_pkg::quat_type          bsel;
   logic signed [WW-1:0]       s1_prd_in [4][4];
   logic signed [WW-1:0]       s1_prd_ff [4][4];
   qau_pkg::result_type        s1_simple_in, s1_simple_ff;
   qau_pkg::kind_type          s1_kind_ff;
   qau_pkg::quat_type          s1_a_ff;

   always_comb begin
      bsel = (item_in.kind == qau_pkg::KIND_NORM) ? item_in.a : item_in.b;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            s1_prd_in[i][j] = $signed(item_in.a[i]) * $signed(bsel[j]);
         end
      end
   end

   always_comb begin
      logic [CW:0] sr;
      s1_simple_in = '0;
      sr           = '0;
      case (item_in.kind) inside
         qau_pkg::KIND_ADD, qau_pkg::KIND_SUB: begin
            for (int i = 0; i < 4; i++) begin
               if (item_in.kind == qau_pkg::KIND_SUB)
                  sr = qau_pkg::sat_fn(qau_pkg::ext_comp(item_in.a[i])
                                       - qau_pkg::ext_comp(item_in.b[i]));
               else
                  sr = qau_pkg::sat_fn(qau_pkg::ext_comp(item_in.a[i])
                                       + qau_pkg::ext_comp(item_in.b[i]));
               s1_simple_in.res[i] = sr[CW-1:0];
               s1_simple_in.sat    = s1_simple_in.sat | sr[CW];
            end
         end
         qau_pkg::KIND_CONJ: begin
            s1_simple_in.res[0] = item_in.a[0];
            for (int i = 1; i < 4; i++) begin
               sr = qau_pkg::sat_fn(-qau_pkg::ext_comp(item_in.a[i]));
               s1_simple_in.res[i] = sr[CW-1:0];
               s1_simple_in.sat    = s1_simple_in.sat | sr[CW];
            end
         end
         default: ;
      endcase
   end

   // stage 2: product sums
   logic signed [SW-1:0]  s2_q_in [4];
   logic signed [SW-1:0]  s2_q_ff [4];
   logic signed [SW-1:0]  s2_d_in, s2_d_ff;
   qau_pkg::result_type   s2_simple_ff;
   qau_pkg::kind_type     s2_kind_ff;
   qau_pkg::quat_type     s2_a_ff;

   always_comb begin
      s2_q_in[0] = qau_pkg::ext_word(s1_prd_ff[0][0]) - qau_pkg::ext_word(s1_prd_ff[1][1])
                 - qau_pkg::ext_word(s1_prd_ff[2][2]) - qau_pkg::ext_word(s1_prd_ff[3][3]);
      s2_q_in[1] = qau_pkg::ext_word(s1_prd_ff[1][0]) + qau_pkg::ext_word(s1_prd_ff[0][1])
                 - qau_pkg::ext_word(s1_prd_ff[3][2]) + qau_pkg::ext_word(s1_prd_ff[2][3]);
      s2_q_in[2] = qau_pkg::ext_word(s1_prd_ff[2][0]) + qau_pkg::ext_word(s1_prd_ff[0][2])
                 + qau_pkg::ext_word(s1_prd_ff[3][1]) - qau_pkg::ext_word(s1_prd_ff[1][3]);
      s2_q_in[3] = qau_pkg::ext_word(s1_prd_ff[3][0]) - qau_pkg::ext_word(s1_prd_ff[2][1])
                 + qau_pkg::ext_word(s1_prd_ff[0][3]) + qau_pkg::ext_word(s1_prd_ff[1][2]);
      // dot product, and squared norm when b was replaced by a
      s2_d_in    = qau_pkg::ext_word(s1_prd_ff[0][0]) + qau_pkg::ext_word(s1_prd_ff[1][1])
                 + qau_pkg::ext_word(s1_prd_ff[2][2]) + qau_pkg::ext_word(s1_prd_ff[3][3]);
   end

   // stage 3: saturate quaternion and dot results, coarse leading-one search
   side_type                   s3_side_in, s3_side_ff;
   logic [NW-1:0]              s3_n_in, s3_n_ff;
   logic [GRP_N*8-1:0]         s3_npad;
   logic [GRP_W-1:0]           s3_grp_in, s3_grp_ff;

   always_comb begin
      logic [CW:0] sr;
      sr                 = '0;
      s3_side_in         = '0;
      s3_side_in.is_norm = s2_kind_ff == qau_pkg::KIND_NORM;
      s3_side_in.a       = s2_a_ff;
      s3_n_in            = s2_d_ff[NW-1:0];
      s3_side_in.zero    = s3_n_in == '0;
      case (s2_kind_ff) inside
         qau_pkg::KIND_MUL: begin
            for (int i = 0; i < 4; i++) begin
               sr = qau_pkg::sat_fn(s2_q_ff[i] >>> qau_pkg::FRAC_W);
               s3_side_in.res.res[i] = sr[CW-1:0];
               s3_side_in.res.sat    = s3_side_in.res.sat | sr[CW];
            end
         end
         qau_pkg::KIND_DOT: begin
            sr = qau_pkg::sat_fn(s2_d_ff >>> qau_pkg::FRAC_W);
            s3_side_in.res.scalar = sr[CW-1:0];
            s3_side_in.res.sat    = sr[CW];
         end
         qau_pkg::KIND_ADD, qau_pkg::KIND_SUB, qau_pkg::KIND_CONJ: begin
            s3_side_in.res = s2_simple_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      s3_npad   = {{(GRP_N*8-NW){1'b0}}, s3_n_in};
      s3_grp_in = '0;
      for (int g = 0; g < GRP_N; g++) begin
         if (|s3_npad[g*8 +: 8]) s3_grp_in = GRP_W'(g);
      end
   end

   // stage 4: fine search, exponent pair count h
   side_type         s4_side_in, s4_side_ff;
   logic [NW-1:0]    s4_n_ff;
   logic [7:0]       s4_byte;
   logic [2:0]       s4_bit;
   logic [P_W-1:0]   s4_pos;

   always_comb begin
      logic [GRP_N*8-1:0] npad;
      npad    = {{(GRP_N*8-NW){1'b0}}, s3_n_ff};
      s4_byte = npad[{s3_grp_ff, 3'b000} +: 8];
      s4_bit  = '0;
      for (int b = 0; b < 8; b++) begin
         if (s4_byte[b]) s4_bit = 3'(b);
      end
      s4_pos          = {s3_grp_ff, 3'b000} + {{GRP_W{1'b0}}, s4_bit};
      s4_side_in      = s3_side_ff;
      s4_side_in.h    = s4_pos[P_W-1:1];
   end

   // stage 5: mantissa m in [1,4) as UQ2.62
   side_type                 s5_side_ff;
   qau_pkg::word_type        s5_m_in, s5_m_ff;

   always_comb begin
      logic [NW+QF-1:0] nsh;
      nsh     = {s4_n_ff, {QF{1'b0}}} >> {s4_side_ff.h, 1'b0};
      s5_m_in = nsh[WW-1:0];
   end

   // stage 6: initial guess
   side_type             s6_side_ff;
   qau_pkg::word_type    s6_m_ff, s6_y_ff, s6_y_in;

   always_comb begin
      if (s5_m_ff[WW-1])
         s6_y_in = qau_pkg::Q62_ONE - (s5_m_ff >> 3);
      else
         s6_y_in = qau_pkg::Q62_ONE + (qau_pkg::Q62_ONE >> 2) - (s5_m_ff >> 2);
   end

   // Newton steps
   qau_pkg::word_type m_ch [RSQRT_ITERS+1];
   qau_pkg::word_type y_ch [RSQRT_ITERS+1];
   side_type          side_ln_ff [NL];

   assign m_ch[0] = s6_m_ff;
   assign y_ch[0] = s6_y_ff;

   for (genvar gi = 0; gi < RSQRT_ITERS; gi++) begin : g_newton
      qau_newton u_newton (
         .clock (clock),
         .en    (en),
         .m_in  (m_ch[gi]),
         .y_in  (y_ch[gi]),
         .m_out (m_ch[gi+1]),
         .y_out (y_ch[gi+1])
      );
   end

   // final: a * y, shift by 34 + h, saturate
   logic signed [PL_W-1:0]    f1_pl_in [4], f1_ph_in [4];
   logic signed [PL_W-1:0]    f1_pl_ff [4], f1_ph_ff [4];
   side_type                  f1_side_ff, f2_side_ff, f3_side_ff;
   logic signed [LONG_W-1:0]  f2_prod_in [4], f2_prod_ff [4];
   logic signed [SW-1:0]      f3_shr_in [4], f3_shr_ff [4];
   logic [SH_W-1:0]           f3_sh;
   qau_pkg::result_type       res_in, res_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         f1_pl_in[i] = $signed(side_ln_ff[NL-1].a[i])
                       * $signed({1'b0, y_ch[RSQRT_ITERS][HW-1:0]});
         f1_ph_in[i] = $signed(side_ln_ff[NL-1].a[i])
                       * $signed({1'b0, y_ch[RSQRT_ITERS][WW-1:HW]});
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         f2_prod_in[i] = ({{(LONG_W-PL_W){f1_ph_ff[i][PL_W-1]}}, f1_ph_ff[i]} << HW)
                       + {{(LONG_W-PL_W){f1_pl_ff[i][PL_W-1]}}, f1_pl_ff[i]};
      end
   end

   always_comb begin
      logic signed [LONG_W-1:0] tmp;
      tmp   = '0;
      f3_sh = SH_W'(qau_pkg::NORM_SH_BASE) + {1'b0, f2_side_ff.h};
      for (int i = 0; i < 4; i++) begin
         tmp          = f2_prod_ff[i] >>> f3_sh;
         f3_shr_in[i] = tmp[SW-1:0];
      end
   end

   always_comb begin
      logic [CW:0] sr;
      sr     = '0;
      res_in = f3_side_ff.res;
      if (f3_side_ff.is_norm) begin
         res_in = '0;
         if (f3_side_ff.zero) begin
            res_in.res = f3_side_ff.a;
         end else begin
            for (int i = 0; i < 4; i++) begin
               sr = qau_pkg::sat_fn(f3_shr_ff[i]);
               res_in.res[i] = sr[CW-1:0];
               res_in.sat    = res_in.sat | sr[CW];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prd_ff    <= s1_prd_in;
         s1_simple_ff <= s1_simple_in;
         s1_kind_ff   <= item_in.kind;
         s1_a_ff      <= item_in.a;

         s2_q_ff      <= s2_q_in;
         s2_d_ff      <= s2_d_in;
         s2_simple_ff <= s1_simple_ff;
         s2_kind_ff   <= s1_kind_ff;
         s2_a_ff      <= s1_a_ff;

         s3_side_ff   <= s3_side_in;
         s3_n_ff      <= s3_n_in;
         s3_grp_ff    <= s3_grp_in;

         s4_side_ff   <= s4_side_in;
         s4_n_ff      <= s3_n_ff;

         s5_side_ff   <= s4_side_ff;
         s5_m_ff      <= s5_m_in;

         s6_side_ff   <= s5_side_ff;
         s6_m_ff      <= s5_m_ff;
         s6_y_ff      <= s6_y_in;

         side_ln_ff[0] <= s6_side_ff;
         for (int i = 1; i < NL; i++) side_ln_ff[i] <= side_ln_ff[i-1];

         f1_pl_ff   <= f1_pl_in;
         f1_ph_ff   <= f1_ph_in;
         f1_side_ff <= side_ln_ff[NL-1];

         f2_prod_ff <= f2_prod_in;
         f2_side_ff <= f1_side_ff;

         f3_shr_ff  <= f3_shr_in;
         f3_side_ff <= f2_side_ff;

         res_ff     <= res_in;
      end
   end

   assign result_out = res_ff;

endmodule

[src/quaternion_arithmetic_unit_top.sv]
// Top level of the quaternion arithmetic unit: front end, queue, execution pipeline.
// Depends on qau_pkg, qau_front, qau_fifo, qau_back and assert_macros.svh.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  operation, a_w..a_z, b_w..b_z
//   rsp_      out        rsp_valid/rsp_ready  res_w..res_z, scalar_out, saturated
//
// One item is taken per cycle unless a stalled output holds the pipeline; every operation runs down the same pipeline.
// The depth of the pipeline is set by the chained 64-bit Newton multiplies of the normalize path.
// Reset is synchronous and clears only the valid flags and the queue pointers and count.
// A stalled output freezes the pipeline; the queue keeps the front end taking items until it is full.
`include "assert_macros.svh"

module quaternion_arithmetic_unit_top #(
   parameter int RSQRT_ITERATIONS = qau_pkg::DEF_RSQRT_ITERS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_operation,
   input  logic signed [qau_pkg::COMP_W-1:0]  req_a_w,
   input  logic signed [qau_pkg::COMP_W-1:0]  req_a_x,
   input  logic signed [qau_pkg::COMP_W-1:0]  req_a_y,
   input  logic signed [qau_pkg::COMP_W-1:0]  req_a_z,
   input  logic signed [qau_pkg::COMP_W-1:0]  req_b_w,
   input  logic signed [qau_pkg::COMP_W-1:0]  req_b_x,
   input  logic signed [qau_pkg::COMP_W-1:0]  req_b_y,
   input  logic signed [qau_pkg::COMP_W-1:0]  req_b_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [qau_pkg::COMP_W-1:0]  rsp_res_w,
   output logic signed [qau_pkg::COMP_W-1:0]  rsp_res_x,
   output logic signed [qau_pkg::COMP_W-1:0]  rsp_res_y,
   output logic signed [qau_pkg::COMP_W-1:0]  rsp_res_z,
   output logic signed [qau_pkg::COMP_W-1:0]  rsp_scalar_out,
   output logic                               rsp_saturated
);

   qau_pkg::quat_type        req_a, req_b;
   qau_pkg::item_type        front_item, queue_item;
   qau_pkg::result_type      result;
   qau_pkg::queue_stat_type  queue_stat;
   logic                     front_valid, queue_in_ready;
   logic                     queue_valid, back_ready;
   logic                     dot_shape_ok, limit_hit;

   assign req_a = {req_a_z, req_a_y, req_a_x, req_a_w};
   assign req_b = {req_b_z, req_b_y, req_b_x, req_b_w};

   qau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_op     (req_operation),
      .in_a      (req_a),
      .in_b      (req_b),
      .out_valid (front_valid),
      .out_ready (queue_in_ready),
      .item_out  (front_item)
   );

   qau_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (queue_in_ready),
      .item_in   (front_item),
      .out_valid (queue_valid),
      .out_ready (back_ready),
      .item_out  (queue_item),
      .stat      (queue_stat)
   );

   qau_back #(
      .RSQRT_ITERS (RSQRT_ITERATIONS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_valid),
      .in_ready   (back_ready),
      .item_in    (queue_item),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .result_out (result)
   );

   assign rsp_res_w      = result.res[0];
   assign rsp_res_x      = result.res[1];
   assign rsp_res_y      = result.res[2];
   assign rsp_res_z      = result.res[3];
   assign rsp_scalar_out = result.scalar;
   assign rsp_saturated  = result.sat;

   // a result carries either a quaternion or a scalar, never both
   assign dot_shape_ok = (rsp_scalar_out == '0)
                      || ((rsp_res_w == '0) && (rsp_res_x == '0)
                          && (rsp_res_y == '0) && (rsp_res_z == '0));

   assign limit_hit = (rsp_res_w == qau_pkg::COMP_MAX) || (rsp_res_w == qau_pkg::COMP_MIN)
                   || (rsp_res_x == qau_pkg::COMP_MAX) || (rsp_res_x == qau_pkg::COMP_MIN)
                   || (rsp_res_y == qau_pkg::COMP_MAX) || (rsp_res_y == qau_pkg::COMP_MIN)
                   || (rsp_res_z == qau_pkg::COMP_MAX) || (rsp_res_z == qau_pkg::COMP_MIN)
                   || (rsp_scalar_out == qau_pkg::COMP_MAX)
                   || (rsp_scalar_out == qau_pkg::COMP_MIN);

   `QAU_ASSERT_IMP(a_result_shape, rsp_valid, dot_shape_ok)
   `QAU_ASSERT_IMP(a_sat_at_limit, rsp_valid && rsp_saturated, limit_hit)
   `QAU_ASSERT_NXT(a_queue_stays_full, queue_stat.full && !queue_stat.pop, !queue_in_ready)

endmodule

[verif/tb_quaternion_arithmetic_unit_top.sv]
// Self-checking testbench for quaternion_arithmetic_unit_top: directed and random items,
// predicted in the bench and checked field by field. Depends on qau_pkg and the RTL.
`timescale 1ns / 1ps

module tb_quaternion_arithmetic_unit_top;

   localparam logic [2:0]        OP_RSVD_LO   = 3'd6;
   localparam logic [2:0]        OP_RSVD_HI   = 3'd7;
   localparam qau_pkg::comp_type FX_ONE       = qau_pkg::comp_type'(1) <<< qau_pkg::FRAC_W;
   localparam int                DRAIN_CYCLES = 60;

   typedef struct {
      logic [2:0]        op;
      qau_pkg::comp_type a [4];
      qau_pkg::comp_type b [4];
      logic              hold;
   } quat_req_type;

   typedef struct {
      qau_pkg::comp_type res [4];
      qau_pkg::comp_type scalar;
      logic              sat;
   } quat_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_operation = '0;
   qau_pkg::comp_type req_a_w = '0, req_a_x = '0, req_a_y = '0, req_a_z = '0;
   qau_pkg::comp_type req_b_w = '0, req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   qau_pkg::comp_type rsp_res_w, rsp_res_x, rsp_res_y, rsp_res_z, rsp_scalar_out;
   logic rsp_saturated;

   quat_req_type pending_reqs [$];
   quat_rsp_type expected_rsps [$];
   quat_req_type cur_req;
   int errors = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int long_hold = 0;
   int rsp_count = 0;
   bit long_hold_done = 0;
   bit burst_mode = 0;

   always #10 clock = ~clock;

   quaternion_arithmetic_unit_top i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_operation,
      .req_a_w, .req_a_x, .req_a_y, .req_a_z, .req_b_w, .req_b_x, .req_b_y, .req_b_z,
      .rsp_valid, .rsp_ready, .rsp_res_w, .rsp_res_x, .rsp_res_y, .rsp_res_z,
      .rsp_scalar_out, .rsp_saturated
   );

   function automatic qau_pkg::comp_type clip(input logic signed [127:0] x, inout logic flag);
      logic signed [127:0] top_val;
      logic signed [127:0] bot_val;
      top_val = qau_pkg::COMP_MAX;
      bot_val = qau_pkg::COMP_MIN;
      if (x > top_val) begin
         flag = 1'b1;
         return qau_pkg::COMP_MAX;
      end
      if (x < bot_val) begin
         flag = 1'b1;
         return qau_pkg::COMP_MIN;
      end
      return qau_pkg::comp_type'(x);
   endfunction

   function automatic logic signed [127:0] wmul(input qau_pkg::comp_type p,
                                                input qau_pkg::comp_type q);
      logic signed [127:0] wp;
      logic signed [127:0] wq;
      wp = p;
      wq = q;
      return wp * wq;
   endfunction

   // Inverse square root by Newton steps on a mantissa held as UQ2.62.
   function automatic void unit_scale(input qau_pkg::comp_type a [4], inout quat_rsp_type r);
      logic [127:0] n;
      logic [127:0] prod;
      logic [63:0] m, y, t, u, v;
      logic signed [127:0] wa, wy;
      int p, s, k, sh;
      n = '0;
      p = -1;
      for (int i = 0; i < 4; i++) n += wmul(a[i], a[i]);
      for (int i = 127; i >= 0; i--) if (p < 0 && n[i]) p = i;
      if (p < 0) begin
         for (int i = 0; i < 4; i++) r.res[i] = a[i];
         return;
      end
      s = p - 62;
      if (s % 2 != 0) s -= 1;
      m = (s >= 0) ? 64'(n >> s) : 64'(n << (-s));
      if (m[63]) y = qau_pkg::Q62_ONE - (m >> 3);
      else       y = qau_pkg::Q62_ONE + (qau_pkg::Q62_ONE >> 2) - (m >> 2);
      for (int i = 0; i < qau_pkg::DEF_RSQRT_ITERS; i++) begin
         prod = {64'd0, y} * {64'd0, y};
         t = prod[125:62];
         prod = {64'd0, m} * {64'd0, t};
         u = prod[125:62];
         v = (u >= qau_pkg::Q62_THREE) ? 64'd0 : qau_pkg::Q62_THREE - u;
         prod = {64'd0, y} * {64'd0, v};
         y = prod[126:63];
      end
      k = (s + 62 - 2 * qau_pkg::FRAC_W) / 2;
      sh = 62 + k;
      wy = $signed(y);
      for (int i = 0; i < 4; i++) begin
         wa = a[i];
         r.res[i] = clip((wa * wy) >>> sh, r.sat);
      end
   endfunction

   function automatic quat_rsp_type quat_result(input quat_req_type q);
      quat_rsp_type r;
      logic signed [127:0] acc [4];
      logic signed [127:0] d;
      r.sat = 1'b0;
      r.scalar = '0;
      for (int i = 0; i < 4; i++) r.res[i] = '0;
      case (q.op)
         qau_pkg::OP_MUL: begin
            acc[0] = wmul(q.b[0], q.a[0]) - wmul(q.b[1], q.a[1])
                   - wmul(q.b[2], q.a[2]) - wmul(q.b[3], q.a[3]);
            acc[1] = wmul(q.b[0], q.a[1]) + wmul(q.b[1], q.a[0])
                   - wmul(q.b[2], q.a[3]) + wmul(q.b[3], q.a[2]);
            acc[2] = wmul(q.b[0], q.a[2]) + wmul(q.a[0], q.b[2])
                   + wmul(q.b[1], q.a[3]) - wmul(q.a[1], q.b[3]);
            acc[3] = wmul(q.b[0], q.a[3]) - wmul(q.b[1], q.a[2])
                   + wmul(q.a[0], q.b[3]) + wmul(q.b[2], q.a[1]);
            for (int i = 0; i < 4; i++) r.res[i] = clip(acc[i] >>> qau_pkg::FRAC_W, r.sat);
         end
         qau_pkg::OP_ADD, qau_pkg::OP_SUB: begin
            for (int i = 0; i < 4; i++) begin
               acc[i] = q.a[i];
               d = q.b[i];
               r.res[i] = clip((q.op == qau_pkg::OP_SUB) ? acc[i] - d : acc[i] + d, r.sat);
            end
         end
         qau_pkg::OP_CONJ: begin
            r.res[0] = q.a[0];
            for (int i = 1; i < 4; i++) begin
               d = q.a[i];
               r.res[i] = clip(-d, r.sat);
            end
         end
         qau_pkg::OP_DOT: begin
            d = '0;
            for (int i = 0; i < 4; i++) d += wmul(q.a[i], q.b[i]);
            r.scalar = clip(d >>> qau_pkg::FRAC_W, r.sat);
         end
         qau_pkg::OP_NORM: unit_scale(q.a, r);
         default: ;
      endcase
      return r;
   endfunction

   task automatic report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic qau_pkg::comp_type rand_comp();
      case ($urandom_range(0, 7))
         0, 1: return qau_pkg::comp_type'($urandom);
         2: case ($urandom_range(0, 4))
               0: return qau_pkg::COMP_MAX;
               1: return qau_pkg::COMP_MIN;
               2: return '0;
               3: return FX_ONE;
               default: return -FX_ONE;
            endcase
         default: return qau_pkg::comp_type'($signed($urandom) >>> $urandom_range(2, 30));
      endcase
   endfunction

   task automatic add_req(input logic [2:0] op, input qau_pkg::comp_type av,
                          input qau_pkg::comp_type bv, input logic hold);
      quat_req_type q;
      q.op = op;
      q.hold = hold;
      for (int i = 0; i < 4; i++) begin
         q.a[i] = av;
         q.b[i] = bv;
      end
      pending_reqs.push_back(q);
   endtask

   // Driver: present one transfer at a time, hold it until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) expected_rsps.push_back(quat_result(cur_req));
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0 &&
                      !(pending_reqs[0].hold && expected_rsps.size() > 0)) begin
            cur_req = pending_reqs.pop_front();
            req_operation <= cur_req.op;
            req_a_w <= cur_req.a[0]; req_a_x <= cur_req.a[1];
            req_a_y <= cur_req.a[2]; req_a_z <= cur_req.a[3];
            req_b_w <= cur_req.b[0]; req_b_x <= cur_req.b[1];
            req_b_y <= cur_req.b[2]; req_b_z <= cur_req.b[3];
            req_valid <= 1'b1;
            if ($urandom_range(0, 99) == 0) burst_mode = ~burst_mode;
            if (!burst_mode) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: send_gap = 0;
                  6, 7, 8: send_gap = $urandom_range(1, 3);
                  default: send_gap = $urandom_range(5, 30);
               endcase
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each transfer against the oldest expectation, stall at random.
   always @(posedge clock) begin
      quat_rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               report("result with no expectation pending");
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_res_w !== e.res[0])
                  report($sformatf("res_w %h, want %h", rsp_res_w, e.res[0]));
               if (rsp_res_x !== e.res[1])
                  report($sformatf("res_x %h, want %h", rsp_res_x, e.res[1]));
               if (rsp_res_y !== e.res[2])
                  report($sformatf("res_y %h, want %h", rsp_res_y, e.res[2]));
               if (rsp_res_z !== e.res[3])
                  report($sformatf("res_z %h, want %h", rsp_res_z, e.res[3]));
               if (rsp_scalar_out !== e.scalar)
                  report($sformatf("scalar_out %h, want %h", rsp_scalar_out, e.scalar));
               if (rsp_saturated !== e.sat)
                  report($sformatf("saturated %b, want %b", rsp_saturated, e.sat));
            end
         end
         // hold off long enough once to back the pipeline up into the input
         if (!long_hold_done && rsp_count >= 200) begin
            long_hold_done = 1;
            long_hold = 300;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!burst_mode) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: recv_gap = 0;
                  6, 7, 8: recv_gap = $urandom_range(1, 3);
                  default: recv_gap = $urandom_range(5, 30);
               endcase
            end
         end
      end
   end

   initial begin
      quat_req_type q;
      // extremes and every operation
      add_req(qau_pkg::OP_MUL, qau_pkg::COMP_MAX, qau_pkg::COMP_MAX, 0);
      add_req(qau_pkg::OP_MUL, qau_pkg::COMP_MIN, qau_pkg::COMP_MIN, 0);
      add_req(qau_pkg::OP_MUL, FX_ONE, -FX_ONE, 0);
      add_req(qau_pkg::OP_ADD, qau_pkg::COMP_MAX, qau_pkg::COMP_MAX, 0);
      add_req(qau_pkg::OP_ADD, qau_pkg::COMP_MIN, qau_pkg::COMP_MIN, 0);
      add_req(qau_pkg::OP_ADD, FX_ONE, -FX_ONE, 0);
      add_req(qau_pkg::OP_SUB, qau_pkg::COMP_MIN, qau_pkg::COMP_MAX, 0);
      add_req(qau_pkg::OP_SUB, qau_pkg::COMP_MAX, qau_pkg::COMP_MIN, 0);
      add_req(qau_pkg::OP_CONJ, qau_pkg::COMP_MIN, '0, 0);
      add_req(qau_pkg::OP_CONJ, qau_pkg::COMP_MAX, qau_pkg::COMP_MIN, 0);
      add_req(qau_pkg::OP_DOT, qau_pkg::COMP_MAX, qau_pkg::COMP_MAX, 0);
      add_req(qau_pkg::OP_DOT, qau_pkg::COMP_MIN, qau_pkg::COMP_MAX, 0);
      add_req(qau_pkg::OP_DOT, FX_ONE, FX_ONE, 0);
      add_req(qau_pkg::OP_NORM, '0, qau_pkg::COMP_MAX, 0);       // zero norm passes through
      add_req(qau_pkg::OP_NORM, qau_pkg::comp_type'(1), '0, 0);  // smallest norm
      add_req(qau_pkg::OP_NORM, qau_pkg::COMP_MAX, '0, 0);
      add_req(qau_pkg::OP_NORM, qau_pkg::COMP_MIN, '0, 0);
      add_req(qau_pkg::OP_NORM, FX_ONE >>> 1, '0, 0);
      add_req(OP_RSVD_LO, qau_pkg::COMP_MAX, qau_pkg::COMP_MIN, 0);
      add_req(OP_RSVD_HI, qau_pkg::COMP_MIN, qau_pkg::COMP_MAX, 0);
      for (int n = 0; n < 950; n++) begin
         q.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
         q.hold = (n == 500 || n == 800);
         for (int i = 0; i < 4; i++) begin
            q.a[i] = rand_comp();
            q.b[i] = rand_comp();
         end
         pending_reqs.push_back(q);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
